// ===== hw/rtl/ntcrt_pkg.sv =====
// ntcrt_pkg: widths, table size, status structs and the resistance table
// shared by the thermistor converter modules; depends on nothing
package ntcrt_pkg;

	localparam int TABLE_ENTRIES = 141;
	localparam int ROM_SIZE      = 141;
	localparam int USED_ENTRIES  = (TABLE_ENTRIES < ROM_SIZE) ?
		((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES) : ROM_SIZE;

	localparam int RES_W  = 24;
	localparam int TEMP_W = 11;
	localparam int ROM_W  = 18;
	localparam int IDX_W  = $clog2(ROM_SIZE);
	localparam int Q_W    = 4;
	localparam int NUM_W  = ROM_W + Q_W;
	localparam int DSH_W  = ROM_W + Q_W - 1;
	localparam int MUL_W  = IDX_W + 4;

	localparam logic [Q_W-1:0]    Q_MAX    = Q_W'(10);
	localparam logic [TEMP_W-1:0] TEMP_MAX = TEMP_W'(10 * (USED_ENTRIES - 1));

	// ohms per degree, -40 C upward, strictly falling
	localparam logic [ROM_W-1:0] OHM_ROM [ROM_SIZE] = '{
		203750, 192049, 181156, 171001, 161522, 152664, 144377, 136617, 129343, 122518,
		116110, 110088, 104425, 99096, 94078, 89350, 84892, 80688, 76720, 72973,
		69434, 66089, 62926, 59935, 57104, 54425, 51888, 49484, 47206, 45047,
		43000, 41057, 39214, 37465, 35804, 34226, 32727, 31303, 29949, 28661,
		27513, 26271, 25162, 24107, 23101, 22144, 21231, 20362, 19533, 18742,
		18016, 17269, 16583, 15928, 15302, 14704, 14134, 13588, 13067, 12568,
		12092, 11636, 11199, 10782, 10382, 10000, 9633, 9282, 8946, 8623,
		8314, 8018, 7734, 7461, 7199, 6948, 6707, 6476, 6254, 6040,
		5835, 5638, 5449, 5267, 5091, 4923, 4761, 4605, 4455, 4311,
		4168, 4038, 3909, 3785, 3665, 3550, 3439, 3332, 3229, 3129,
		3033, 2941, 2851, 2765, 2682, 2602, 2524, 2449, 2377, 2307,
		2240, 2175, 2112, 2051, 1992, 1935, 1880, 1827, 1776, 1726,
		1678, 1632, 1587, 1543, 1501, 1461, 1421, 1383, 1346, 1310,
		1275, 1242, 1209, 1178, 1147, 1117, 1089, 1061, 1034, 1008,
		983
	};

	function automatic logic [ROM_W-1:0] rom_read(input logic [IDX_W-1:0] idx);
		logic [ROM_W-1:0] v;
		v = '0;
		if (int'(idx) < ROM_SIZE) begin
			v = OHM_ROM[idx];
		end
		return v;
	endfunction

	typedef struct packed {
		logic             done;
		logic             clamp_lo;
		logic             clamp_hi;
		logic             exact;
		logic [IDX_W-1:0] idx;
		logic [ROM_W-1:0] diff;
		logic [ROM_W-1:0] den;
	} srch_res_t;

	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] q;
	} div_res_t;

endpackage

// ===== hw/rtl/ntcrt_res_if.sv =====
// ntcrt_res_if: input channel carrying one resistance sample per beat
// depends on ntcrt_pkg
interface ntcrt_res_if;
	logic                        valid;
	logic                        ready;
	logic [ntcrt_pkg::RES_W-1:0] resistance_ohms;

	modport source(output valid, output resistance_ohms, input ready);
	modport sink(input valid, input resistance_ohms, output ready);
endinterface

// ===== hw/rtl/ntcrt_temp_if.sv =====
// ntcrt_temp_if: output channel carrying one temperature per beat
// depends on ntcrt_pkg
interface ntcrt_temp_if;
	logic                         valid;
	logic                         ready;
	logic [ntcrt_pkg::TEMP_W-1:0] temp_tenths;

	modport source(output valid, output temp_tenths, input ready);
	modport sink(input valid, input temp_tenths, output ready);
endinterface

// ===== hw/rtl/ntc_resistance_to_temperature.sv =====
// ntc_resistance_to_temperature: thermistor ohms to tenths of a degree from -40 C
// flow: clamps and exact table hits go from the search straight to the output register;
//   other values run the search probes and then the divider (4 divide bits)
// one sample in flight; a result waits in ST_PUSH until the output register has room
// reset: arst_n clears the sequencer, the search and divider control, output valid
// depends on ntcrt_pkg, ntcrt_res_if, ntcrt_temp_if, ntcrt_search, ntcrt_div
module ntc_resistance_to_temperature (
	input  logic               clk,
	input  logic               arst_n,
	ntcrt_res_if.sink          sample,
	ntcrt_temp_if.source       result
);

	// sequencer states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_PUSH   = 2'd3;

	logic [1:0]                     state_q;
	logic [1:0]                     state_next;
	logic [ntcrt_pkg::TEMP_W-1:0]   res_q;
	logic [ntcrt_pkg::TEMP_W-1:0]   res_next;
	logic                           res_load;
	logic [ntcrt_pkg::IDX_W-1:0]    idx_q;
	logic                           out_valid_q;
	logic [ntcrt_pkg::TEMP_W-1:0]   out_temp_q;

	logic                           srch_start;
	logic                           div_start;
	logic                           out_load;
	ntcrt_pkg::srch_res_t           srch_stat;
	ntcrt_pkg::div_res_t            div_stat;

	// 10 * k - q, kept to the field width
	function automatic logic [ntcrt_pkg::TEMP_W-1:0] tenths(
		input logic [ntcrt_pkg::IDX_W-1:0] k,
		input logic [ntcrt_pkg::Q_W-1:0]   q
	);
		logic [ntcrt_pkg::MUL_W-1:0] t;
		t = (ntcrt_pkg::MUL_W'(k) << 3) + (ntcrt_pkg::MUL_W'(k) << 1)
			- ntcrt_pkg::MUL_W'(q);
		return t[ntcrt_pkg::TEMP_W-1:0];
	endfunction

	// input beat is taken only when nothing is in flight
	assign sample.ready = (state_q == ST_IDLE);
	assign srch_start   = sample.valid && sample.ready;

	ntcrt_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (srch_start),
		.res    (sample.resistance_ohms),
		.stat   (srch_stat)
	);

	ntcrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (srch_stat.diff),
		.den    (srch_stat.den),
		.res    (div_stat)
	);

	always_comb begin
		state_next = state_q;
		res_next   = res_q;
		res_load   = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (srch_start) begin
					state_next = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (srch_stat.done) begin
					// clamps and exact hits skip the divider
					priority if (srch_stat.clamp_lo) begin
						res_next   = '0;
						res_load   = 1'b1;
						state_next = ST_PUSH;
					end else if (srch_stat.clamp_hi) begin
						res_next   = ntcrt_pkg::TEMP_MAX;
						res_load   = 1'b1;
						state_next = ST_PUSH;
					end else if (srch_stat.exact) begin
						res_next   = tenths(srch_stat.idx, '0);
						res_load   = 1'b1;
						state_next = ST_PUSH;
					end else begin
						div_start  = 1'b1;
						state_next = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					res_next   = tenths(idx_q, div_stat.q);
					res_load   = 1'b1;
					state_next = ST_PUSH;
				end
			end
			ST_PUSH: begin
				// wait for room in the output register
				if (!out_valid_q || result.ready) begin
					out_load   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_next;
		end
		if (div_start) begin
			idx_q <= srch_stat.idx;
		end
		if (out_load) begin
			out_temp_q <= res_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.temp_tenths = out_temp_q;

	a_srch_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		srch_stat.done |-> state_q == ST_SEARCH)
		else $error("search finished outside search state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_temp_q <= ntcrt_pkg::TEMP_MAX)
		else $error("temperature beyond table range");

endmodule

// ===== hw/rtl/ntcrt_search.sv =====
// ntcrt_search: binary search of the resistance table, one probe per cycle
// depends on ntcrt_pkg
module ntcrt_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ntcrt_pkg::RES_W-1:0] res,
	output ntcrt_pkg::srch_res_t        stat
);

	logic                          busy_q;
	logic                          done_q;
	logic [ntcrt_pkg::RES_W-1:0]   r_q;
	logic [ntcrt_pkg::IDX_W-1:0]   lo_q;
	logic [ntcrt_pkg::IDX_W-1:0]   hi_q;
	logic                          clamp_lo_q;
	logic                          clamp_hi_q;
	logic                          exact_q;
	logic [ntcrt_pkg::IDX_W-1:0]   idx_q;
	logic [ntcrt_pkg::ROM_W-1:0]   diff_q;
	logic [ntcrt_pkg::ROM_W-1:0]   den_q;

	logic [ntcrt_pkg::IDX_W:0]     mid_sum;
	logic [ntcrt_pkg::IDX_W-1:0]   mid;
	logic [ntcrt_pkg::ROM_W-1:0]   t_mid;
	logic [ntcrt_pkg::ROM_W-1:0]   t_b;
	logic [ntcrt_pkg::ROM_W-1:0]   t_b1;
	logic [ntcrt_pkg::ROM_W-1:0]   diff;
	logic                          last;
	logic                          go_hi;

	always_comb begin
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid     = mid_sum[ntcrt_pkg::IDX_W:1];
		t_mid   = ntcrt_pkg::rom_read(mid);
		t_b     = ntcrt_pkg::rom_read(hi_q);
		t_b1    = ntcrt_pkg::rom_read(lo_q);
		// no clamp means r is below the first entry, so its low bits are exact
		diff    = r_q[ntcrt_pkg::ROM_W-1:0] - t_b;
		last    = clamp_lo_q || clamp_hi_q || (hi_q == (lo_q + ntcrt_pkg::IDX_W'(1)));
		go_hi   = (ntcrt_pkg::RES_W'(t_mid) <= r_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q        <= res;
			clamp_lo_q <= (res >= ntcrt_pkg::RES_W'(ntcrt_pkg::OHM_ROM[0]));
			clamp_hi_q <= (res <= ntcrt_pkg::RES_W'(
				ntcrt_pkg::OHM_ROM[ntcrt_pkg::USED_ENTRIES - 1]));
			lo_q       <= '0;
			hi_q       <= ntcrt_pkg::IDX_W'(ntcrt_pkg::USED_ENTRIES - 1);
		end else if (busy_q) begin
			if (last) begin
				exact_q <= (diff == '0);
				idx_q   <= hi_q;
				diff_q  <= diff;
				den_q   <= t_b1 - t_b;
			end else if (go_hi) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid;
			end
		end
	end

	assign stat.done     = done_q;
	assign stat.clamp_lo = clamp_lo_q;
	assign stat.clamp_hi = clamp_hi_q;
	assign stat.exact    = exact_q;
	assign stat.idx      = idx_q;
	assign stat.diff     = diff_q;
	assign stat.den      = den_q;

	// bracket stays ordered while probing
	a_bracket_order: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> lo_q < hi_q)
		else $error("search bracket out of order");

endmodule

// ===== hw/rtl/ntcrt_div.sv =====
// ntcrt_div: restoring divider, one quotient bit per cycle, rounding up
// depends on ntcrt_pkg
module ntcrt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ntcrt_pkg::ROM_W-1:0] diff,
	input  logic [ntcrt_pkg::ROM_W-1:0] den,
	output ntcrt_pkg::div_res_t         res
);

	localparam int CNT_W = $clog2(ntcrt_pkg::Q_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [ntcrt_pkg::NUM_W-1:0]   rem_q;
	logic [ntcrt_pkg::DSH_W-1:0]   dsh_q;
	logic [ntcrt_pkg::Q_W-1:0]     q_q;

	logic [ntcrt_pkg::NUM_W-1:0]   num;
	logic [ntcrt_pkg::NUM_W-1:0]   dsh_ext;
	logic                          fits;

	always_comb begin
		// 10 * diff + den - 1, so the floor below gives the ceiling
		num = (ntcrt_pkg::NUM_W'(diff) << 3) + (ntcrt_pkg::NUM_W'(diff) << 1)
			+ ntcrt_pkg::NUM_W'(den) - ntcrt_pkg::NUM_W'(1);
		dsh_ext = ntcrt_pkg::NUM_W'(dsh_q);
		fits    = (dsh_ext <= rem_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ntcrt_pkg::Q_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= ntcrt_pkg::DSH_W'(den) << (ntcrt_pkg::Q_W - 1);
			q_q   <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_ext;
			end
			q_q   <= {q_q[ntcrt_pkg::Q_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign res.done = done_q;
	assign res.q    = q_q;

	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (q_q != '0) && (q_q <= ntcrt_pkg::Q_MAX))
		else $error("interpolation step out of range");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

// ===== bench/ntcrt_checker.sv =====
`timescale 1ns / 1ps
// ntcrt_checker: watches the resistance and temperature channels, predicts each
// temperature from its own copy of the ohm table and compares results in order
// depends on ntcrt_pkg, ntcrt_res_if, ntcrt_temp_if
module ntcrt_checker (
	input  logic  clk,
	input  logic  arst_n,
	ntcrt_res_if  sample,
	ntcrt_temp_if result,
	output int    mismatches,
	output int    outstanding,
	output int    checked,
	output int    clamped,
	output int    exact_hits,
	output int    interpolated
);

	typedef enum logic [1:0] {
		SPAN_CLAMP,
		SPAN_EXACT,
		SPAN_INTERP
	} span_t;

	// ohms per degree from -40 C, falling
	localparam int unsigned OHM_TABLE [141] = '{
		203750, 192049, 181156, 171001, 161522, 152664, 144377, 136617, 129343, 122518,
		116110, 110088, 104425, 99096, 94078, 89350, 84892, 80688, 76720, 72973,
		69434, 66089, 62926, 59935, 57104, 54425, 51888, 49484, 47206, 45047,
		43000, 41057, 39214, 37465, 35804, 34226, 32727, 31303, 29949, 28661,
		27513, 26271, 25162, 24107, 23101, 22144, 21231, 20362, 19533, 18742,
		18016, 17269, 16583, 15928, 15302, 14704, 14134, 13588, 13067, 12568,
		12092, 11636, 11199, 10782, 10382, 10000, 9633, 9282, 8946, 8623,
		8314, 8018, 7734, 7461, 7199, 6948, 6707, 6476, 6254, 6040,
		5835, 5638, 5449, 5267, 5091, 4923, 4761, 4605, 4455, 4311,
		4168, 4038, 3909, 3785, 3665, 3550, 3439, 3332, 3229, 3129,
		3033, 2941, 2851, 2765, 2682, 2602, 2524, 2449, 2377, 2307,
		2240, 2175, 2112, 2051, 1992, 1935, 1880, 1827, 1776, 1726,
		1678, 1632, 1587, 1543, 1501, 1461, 1421, 1383, 1346, 1310,
		1275, 1242, 1209, 1178, 1147, 1117, 1089, 1061, 1034, 1008,
		983
	};

	logic [ntcrt_pkg::TEMP_W-1:0] expected_temps [$];

	// temperature for one resistance, plus which part of the curve it hit
	function automatic logic [ntcrt_pkg::TEMP_W-1:0] predict_temp(
			input logic [ntcrt_pkg::RES_W-1:0] ohms, output span_t kind);
		int unsigned n, k, lo, den, num, q, t;
		logic found;
		n = ntcrt_pkg::USED_ENTRIES;
		kind = SPAN_CLAMP;
		t = 10 * (n - 1);
		found = 1'b0;
		if (ohms >= OHM_TABLE[0]) begin
			t = 0;
		end else if (ohms > OHM_TABLE[n-1]) begin
			for (k = 1; k < n && !found; k++) begin
				lo = OHM_TABLE[k];
				if (ohms == lo) begin
					t = 10 * k;
					kind = SPAN_EXACT;
					found = 1'b1;
				end else if (ohms > lo) begin
					// round the fraction up: colder side of the bracket
					den = OHM_TABLE[k-1] - lo;
					num = 10 * (ohms - lo);
					q = (num + den - 1) / den;
					t = 10 * k - q;
					kind = SPAN_INTERP;
					found = 1'b1;
				end
			end
		end
		return ntcrt_pkg::TEMP_W'(t);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [ntcrt_pkg::TEMP_W-1:0] want;
		span_t kind;
		if (!arst_n) begin
			expected_temps.delete();
			mismatches   <= 0;
			outstanding  <= 0;
			checked      <= 0;
			clamped      <= 0;
			exact_hits   <= 0;
			interpolated <= 0;
		end else begin
			if (sample.valid && sample.ready) begin
				want = predict_temp(sample.resistance_ohms, kind);
				expected_temps.push_back(want);
				case (kind)
					SPAN_CLAMP: begin
						clamped <= clamped + 1;
					end
					SPAN_EXACT: begin
						exact_hits <= exact_hits + 1;
					end
					default: begin
						interpolated <= interpolated + 1;
					end
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_temps.size() == 0) begin
					$error("temp_tenths: expected none, actual %0d", result.temp_tenths);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_temps.pop_front();
					checked <= checked + 1;
					if (result.temp_tenths !== want) begin
						$error("temp_tenths: expected %0d, actual %0d", want,
							result.temp_tenths);
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= expected_temps.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives resistance beats into the thermistor converter and takes
// temperature beats out under several handshake mixes; ntcrt_checker judges
// depends on ntcrt_pkg, ntcrt_res_if, ntcrt_temp_if, ntcrt_checker, the converter
module testbench;

	// generous: far above what a slow run needs
	localparam int CYCLE_LIMIT = 1000000;
	// drain margin past the longest converter latency (interpolation)
	localparam int TAIL_CYCLES = 40;
	localparam int PHASE_BEATS = 260;

	// corners: zero and full scale, both clamp edges, exact hits, neighbors
	// of entries, and alternating bit patterns
	localparam logic [ntcrt_pkg::RES_W-1:0] CORNER_OHMS [23] = '{
		24'd0, 24'd1, 24'd982, 24'd983, 24'd984, 24'd1008, 24'd1009,
		24'd9999, 24'd10000, 24'd10001, 24'd27513, 24'd28000, 24'd192049,
		24'd192050, 24'd200000, 24'd203749, 24'd203750, 24'd203751,
		24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555
	};

	logic clk;
	logic arst_n;

	int mismatches;
	int outstanding;
	int checked;
	int clamped;
	int exact_hits;
	int interpolated;

	// percent of cycles the sender sits idle / the receiver holds off
	int send_idle_pct;
	int recv_stall_pct;

	ntcrt_res_if  sample_ch ();
	ntcrt_temp_if result_ch ();

	ntc_resistance_to_temperature u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	ntcrt_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample_ch),
		.result       (result_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.checked      (checked),
		.clamped      (clamped),
		.exact_hits   (exact_hits),
		.interpolated (interpolated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// receiver side: ready redrawn every cycle from the current stall rate
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one beat: optional idle gap with valid low, then hold valid until taken;
	// valid is only raised here, so back-to-back beats never toggle it
	task automatic send_beat(input logic [ntcrt_pkg::RES_W-1:0] ohms);
		if ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid           <= 1'b0;
			sample_ch.resistance_ohms <= ntcrt_pkg::RES_W'($urandom);
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.resistance_ohms <= ohms;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// sender holds off until every temperature in flight has come back;
	// the first edge lets the checker register the last accepted beat
	task automatic wait_drained();
		do @(posedge clk); while (outstanding != 0);
	endtask

	// random beats, mostly inside the table so the search and the divider
	// get real work, with clamps and raw 24-bit values mixed in
	task automatic run_phase(input int beats, input int idle_pct, input int stall_pct);
		int draw;
		int unsigned b;
		logic [ntcrt_pkg::RES_W-1:0] ohms;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < beats; i++) begin
			draw = $urandom_range(99);
			b    = $urandom_range(ntcrt_pkg::USED_ENTRIES - 1, 1);
			if (draw < 40) begin
				// strictly inside or on the edges of one bracket
				ohms = ntcrt_pkg::RES_W'($urandom_range(ntcrt_pkg::OHM_ROM[b-1],
					ntcrt_pkg::OHM_ROM[b]));
			end else if (draw < 55) begin
				ohms = ntcrt_pkg::RES_W'(ntcrt_pkg::OHM_ROM[b]);
			end else if (draw < 70) begin
				// one ohm off an entry, either side
				ohms = $urandom_range(1) ? ntcrt_pkg::RES_W'(ntcrt_pkg::OHM_ROM[b] + 1)
					: ntcrt_pkg::RES_W'(ntcrt_pkg::OHM_ROM[b] - 1);
			end else if (draw < 80) begin
				ohms = ntcrt_pkg::RES_W'($urandom);
			end else if (draw < 90) begin
				// at or below the hottest entry
				ohms = ntcrt_pkg::RES_W'($urandom_range(
					ntcrt_pkg::OHM_ROM[ntcrt_pkg::USED_ENTRIES-1]));
			end else begin
				// at or above the coldest entry, up to full scale
				ohms = ntcrt_pkg::RES_W'($urandom_range(24'hFFFFFF, ntcrt_pkg::OHM_ROM[0]));
			end
			send_beat(ohms);
		end
		// sender goes quiet while the converter drains between phases
		sample_ch.valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		arst_n                    = 1'b0;
		sample_ch.valid           = 1'b0;
		sample_ch.resistance_ohms = '0;
		send_idle_pct             = 0;
		recv_stall_pct            = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, full speed on both sides
		foreach (CORNER_OHMS[i]) begin
			send_beat(CORNER_OHMS[i]);
		end
		sample_ch.valid <= 1'b0;
		wait_drained();

		// handshake mixes: none, sender idle, receiver stalling, both lightly
		run_phase(PHASE_BEATS, 0, 0);
		run_phase(PHASE_BEATS, 88, 0);
		run_phase(PHASE_BEATS, 0, 88);
		run_phase(PHASE_BEATS, 17, 17);

		// let any stray late beat show up before the verdict
		recv_stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d temperatures checked over corner values and four handshake mixes",
			checked);
		$display("summary: %0d clamped, %0d exact table hits, %0d interpolated",
			clamped, exact_hits, interpolated);
		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
